@@ hw/rtl/mdfs_pkg.sv @@
// ----------------------------------------------------------------------------
// mdfs_pkg
// shared types and constants of the depth-first maze path solver
// ----------------------------------------------------------------------------
package mdfs_pkg;

  // fixed field and storage sizes
  localparam int CoordW    = 6;
  localparam int IndexW    = 12;
  localparam int DepthW    = 13;
  localparam int StackCap  = 4096;
  localparam int StackAw   = 12;
  localparam int EpochW    = 8;
  localparam int CfgIdxW   = 3;

  // configuration register indexes
  localparam logic [CfgIdxW-1:0] CFG_WIDTH  = 3'd0;
  localparam logic [CfgIdxW-1:0] CFG_HEIGHT = 3'd1;
  localparam logic [CfgIdxW-1:0] CFG_STARTX = 3'd2;
  localparam logic [CfgIdxW-1:0] CFG_STARTY = 3'd3;
  localparam logic [CfgIdxW-1:0] CFG_GOALX  = 3'd4;
  localparam logic [CfgIdxW-1:0] CFG_GOALY  = 3'd5;

  // operation codes of an input item
  typedef enum logic [1:0] {
    OP_CLEAR = 2'd0,
    OP_BLOCK = 2'd1,
    OP_SOLVE = 2'd2,
    OP_READ  = 2'd3
  } op_e;

  // status codes of a result item
  typedef enum logic [1:0] {
    ST_OK    = 2'd0,
    ST_RANGE = 2'd1,
    ST_INDEX = 2'd2
  } status_e;

  typedef struct packed {
    logic [1:0]        operation;
    logic [CoordW-1:0] cell_x;
    logic [CoordW-1:0] cell_y;
    logic [IndexW-1:0] path_index;
  } in_item_t;

  typedef struct packed {
    logic [1:0]        status;
    logic              found;
    logic [DepthW-1:0] path_length;
    logic [CoordW-1:0] out_x;
    logic [CoordW-1:0] out_y;
  } out_item_t;

  // one path stack entry
  typedef struct packed {
    logic [CoordW-1:0] x;
    logic [CoordW-1:0] y;
  } stack_entry_t;

  // requests from the search engine to the cell map
  typedef struct packed {
    logic wall_clear;
    logic vis_clear;
    logic wall_wr;
    logic vis_wr;
    logic rd;
  } map_cmd_t;

  // cell map read answer, valid the cycle after a read
  typedef struct packed {
    logic wall;
    logic visited;
  } map_probe_t;

endpackage

@@ hw/rtl/mdfs_cell_map.sv @@
// ----------------------------------------------------------------------------
// mdfs_cell_map
// wall and visited maps held as epoch-tagged memories with clearing sweeps
// ----------------------------------------------------------------------------
module mdfs_cell_map #(
  parameter int GridSide = 64,
  localparam int CellCount = GridSide * GridSide,
  localparam int CellAw = $clog2(CellCount)
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  mdfs_pkg::map_cmd_t    cmd_i,
  input  logic [CellAw-1:0]     addr_i,
  output logic                  busy_o,
  output mdfs_pkg::map_probe_t  probe_o
);

  localparam logic [CellAw-1:0] LastAddr = CellAw'(CellCount - 1);

  logic [mdfs_pkg::EpochW-1:0] wall_mem [CellCount];
  logic [mdfs_pkg::EpochW-1:0] vis_mem  [CellCount];

  logic [mdfs_pkg::EpochW-1:0] wall_ep_q, vis_ep_q;
  logic [mdfs_pkg::EpochW-1:0] wall_rd_q, vis_rd_q;
  logic                        sweep_wall_q, sweep_vis_q;
  logic [CellAw-1:0]           sweep_addr_q;

  logic                        wall_we, vis_we;
  logic [CellAw-1:0]           wall_wa, vis_wa;
  logic [mdfs_pkg::EpochW-1:0] wall_wd, vis_wd;

  assign busy_o = sweep_wall_q | sweep_vis_q;

  // write port select: sweep wins, it only runs while the engine waits
  always_comb begin
    wall_we = sweep_wall_q | cmd_i.wall_wr;
    wall_wa = sweep_wall_q ? sweep_addr_q : addr_i;
    wall_wd = sweep_wall_q ? '0 : wall_ep_q;
    vis_we  = sweep_vis_q | cmd_i.vis_wr;
    vis_wa  = sweep_vis_q ? sweep_addr_q : addr_i;
    vis_wd  = sweep_vis_q ? '0 : vis_ep_q;
  end

  // memories, one write and one registered read each
  always_ff @(posedge clk_i) begin
    if (wall_we) begin
      wall_mem[wall_wa] <= wall_wd;
    end
    if (vis_we) begin
      vis_mem[vis_wa] <= vis_wd;
    end
    if (cmd_i.rd) begin
      wall_rd_q <= wall_mem[addr_i];
      vis_rd_q  <= vis_mem[addr_i];
    end
  end

  // an entry counts only when its tag matches the current epoch
  assign probe_o.wall    = (wall_rd_q == wall_ep_q);
  assign probe_o.visited = (vis_rd_q == vis_ep_q);

  // epochs and clearing sweeps
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wall_ep_q    <= mdfs_pkg::EpochW'(1);
      vis_ep_q     <= mdfs_pkg::EpochW'(1);
      sweep_wall_q <= 1'b1;
      sweep_vis_q  <= 1'b1;
      sweep_addr_q <= '0;
    end else begin
      if (busy_o) begin
        if (sweep_addr_q == LastAddr) begin
          sweep_wall_q <= 1'b0;
          sweep_vis_q  <= 1'b0;
          sweep_addr_q <= '0;
        end else begin
          sweep_addr_q <= sweep_addr_q + CellAw'(1);
        end
      end
      if (cmd_i.wall_clear) begin
        if (wall_ep_q == '1) begin
          wall_ep_q    <= mdfs_pkg::EpochW'(1);
          sweep_wall_q <= 1'b1;
          sweep_addr_q <= '0;
        end else begin
          wall_ep_q <= wall_ep_q + mdfs_pkg::EpochW'(1);
        end
      end
      if (cmd_i.vis_clear) begin
        if (vis_ep_q == '1) begin
          vis_ep_q     <= mdfs_pkg::EpochW'(1);
          sweep_vis_q  <= 1'b1;
          sweep_addr_q <= '0;
        end else begin
          vis_ep_q <= vis_ep_q + mdfs_pkg::EpochW'(1);
        end
      end
    end
  end

endmodule

@@ hw/rtl/maze_dfs_path_solver.sv @@
// ----------------------------------------------------------------------------
// maze_dfs_path_solver
// grid maze solver: depth-first search over a wall map, path kept on a stack
// ----------------------------------------------------------------------------
//  channel  direction  handshake               payload
//  cfg      in         cfg_we_i                cfg_idx_i, cfg_data_i
//  in       in         in_valid_i, in_stall_o  in_item_i (mdfs_pkg::in_item_t)
//  out      out        out_valid_o, out_stall_i out_item_o (mdfs_pkg::out_item_t)
//
//  a read first waits on the path stack; the result sits in an output register
//  a solve: push the start, then check each new top for the goal, step past each
//  neighbor outside the interior, probe and evaluate each inner one, wait on each pop;
//  the wall/visited memory port serves one probe at a time
//  after reset, and on every 255th clear or solve, a sweep over all GRID_SIDE*GRID_SIDE
//  cells clears the maps; no item is taken meanwhile
//  a stalled output holds its result; the next item is still taken, and its
//  result waits until the output register frees
// ----------------------------------------------------------------------------
module maze_dfs_path_solver #(
  parameter int GRID_SIDE = 64
) (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                cfg_we_i,
  input  logic [mdfs_pkg::CfgIdxW-1:0]        cfg_idx_i,
  input  logic [mdfs_pkg::CoordW-1:0]         cfg_data_i,
  input  logic                                in_valid_i,
  output logic                                in_stall_o,
  input  mdfs_pkg::in_item_t                  in_item_i,
  output logic                                out_valid_o,
  input  logic                                out_stall_i,
  output mdfs_pkg::out_item_t                 out_item_o
);

  localparam int CellAw = $clog2(GRID_SIDE * GRID_SIDE);
  localparam int DW     = mdfs_pkg::DepthW;
  localparam int CW     = mdfs_pkg::CoordW;
  localparam logic [DW-1:0] DepthFull = DW'(mdfs_pkg::StackCap);

  typedef enum logic [2:0] {
    S_IDLE,
    S_START,
    S_TOP,
    S_PROBE,
    S_EVAL,
    S_POP_WAIT,
    S_READ_WAIT,
    S_DONE
  } state_e;

  state_e              state_q;
  logic [CW-1:0]       width_q, height_q, start_x_q, start_y_q, goal_x_q, goal_y_q;
  logic [CW-1:0]       top_x_q, top_y_q;
  logic [1:0]          dir_q;
  logic [DW-1:0]       depth_q;
  logic                found_q;
  logic [1:0]          status_q;
  logic [CW-1:0]       rx_q, ry_q;
  logic                out_valid_q;
  mdfs_pkg::out_item_t out_item_q;

  mdfs_pkg::map_cmd_t     map_cmd;
  logic [CellAw-1:0]      map_addr;
  logic                   map_busy;
  mdfs_pkg::map_probe_t   probe;

  mdfs_pkg::stack_entry_t stk_mem [mdfs_pkg::StackCap];
  mdfs_pkg::stack_entry_t stk_rd_q, stk_wd;
  logic                   stk_we, stk_re;
  logic [mdfs_pkg::StackAw-1:0] stk_wa, stk_ra;

  logic                   accept;
  logic [6:0]             nb_x, nb_y;
  logic                   nb_ok, nb_in, enter, pop_now, start_in_grid, blk_in;
  logic [DW-1:0]          plen, depth_m2;

  // cell inside the configured interior and the grid
  function automatic logic interior(logic [6:0] x, logic [6:0] y,
                                    logic [CW-1:0] w, logic [CW-1:0] h);
    return (x != '0) && (y != '0) && (x <= {1'b0, w}) && (y <= {1'b0, h}) &&
           ({25'd0, x} < 32'(GRID_SIDE)) && ({25'd0, y} < 32'(GRID_SIDE));
  endfunction

  function automatic logic [CellAw-1:0] cell_addr(logic [CW-1:0] x, logic [CW-1:0] y);
    return CellAw'(x) * CellAw'(GRID_SIDE) + CellAw'(y);
  endfunction

  assign accept      = in_valid_i && !in_stall_o;
  assign in_stall_o  = (state_q != S_IDLE) || map_busy;
  assign out_valid_o = out_valid_q;
  assign out_item_o  = out_item_q;
  assign plen        = found_q ? depth_q : '0;
  assign depth_m2    = depth_q - DW'(2);

  // neighbor in the order x+1, y-1, y+1, x-1
  always_comb begin
    nb_x  = {1'b0, top_x_q};
    nb_y  = {1'b0, top_y_q};
    nb_ok = 1'b1;
    case (dir_q)
      2'd0: nb_x = {1'b0, top_x_q} + 7'd1;
      2'd1: begin
        nb_y  = {1'b0, top_y_q} - 7'd1;
        nb_ok = (top_y_q != '0);
      end
      2'd2: nb_y = {1'b0, top_y_q} + 7'd1;
      default: begin
        nb_x  = {1'b0, top_x_q} - 7'd1;
        nb_ok = (top_x_q != '0);
      end
    endcase
  end

  assign nb_in         = nb_ok && interior(nb_x, nb_y, width_q, height_q);
  assign enter         = !probe.wall && !probe.visited;
  assign start_in_grid = ({26'd0, start_x_q} < 32'(GRID_SIDE)) &&
                         ({26'd0, start_y_q} < 32'(GRID_SIDE));
  assign blk_in        = interior({1'b0, in_item_i.cell_x}, {1'b0, in_item_i.cell_y},
                                  width_q, height_q);
  assign pop_now = ((state_q == S_PROBE) &&
                    ((depth_q == DepthFull) || (!nb_in && (dir_q == 2'd3)))) ||
                   ((state_q == S_EVAL) && !enter && (dir_q == 2'd3));

  // memory requests for the current step
  always_comb begin
    map_cmd  = '0;
    map_addr = cell_addr(nb_x[CW-1:0], nb_y[CW-1:0]);
    stk_we   = 1'b0;
    stk_wa   = depth_q[mdfs_pkg::StackAw-1:0];
    stk_wd   = '{x: nb_x[CW-1:0], y: nb_y[CW-1:0]};
    stk_re   = 1'b0;
    stk_ra   = depth_m2[mdfs_pkg::StackAw-1:0];
    case (state_q)
      S_IDLE: begin
        if (accept) begin
          case (in_item_i.operation)
            mdfs_pkg::OP_CLEAR: map_cmd.wall_clear = 1'b1;
            mdfs_pkg::OP_BLOCK: begin
              map_addr        = cell_addr(in_item_i.cell_x, in_item_i.cell_y);
              map_cmd.wall_wr = blk_in;
            end
            mdfs_pkg::OP_SOLVE: map_cmd.vis_clear = 1'b1;
            default: begin
              stk_re = ({1'b0, in_item_i.path_index} < plen);
              stk_ra = in_item_i.path_index;
            end
          endcase
        end
      end
      S_START: begin
        if (!map_busy) begin
          stk_we         = 1'b1;
          stk_wa         = '0;
          stk_wd         = '{x: start_x_q, y: start_y_q};
          map_addr       = cell_addr(start_x_q, start_y_q);
          map_cmd.vis_wr = start_in_grid;
        end
      end
      S_PROBE: begin
        if (pop_now) begin
          stk_re = (depth_q != DW'(1));
        end else begin
          map_cmd.rd = nb_in;
        end
      end
      S_EVAL: begin
        if (enter) begin
          stk_we         = 1'b1;
          map_cmd.vis_wr = 1'b1;
        end else if (pop_now) begin
          stk_re = (depth_q != DW'(1));
        end
      end
      default: ;
    endcase
  end

  // path stack memory
  always_ff @(posedge clk_i) begin
    if (stk_we) begin
      stk_mem[stk_wa] <= stk_wd;
    end
    if (stk_re) begin
      stk_rd_q <= stk_mem[stk_ra];
    end
  end

  mdfs_cell_map #(
    .GridSide(GRID_SIDE)
  ) u_cell_map (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .cmd_i  (map_cmd),
    .addr_i (map_addr),
    .busy_o (map_busy),
    .probe_o(probe)
  );

  // search sequencer, configuration and result register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      width_q     <= CW'(62);
      height_q    <= CW'(62);
      start_x_q   <= CW'(1);
      start_y_q   <= CW'(1);
      goal_x_q    <= CW'(62);
      goal_y_q    <= CW'(62);
      top_x_q     <= '0;
      top_y_q     <= '0;
      dir_q       <= '0;
      depth_q     <= '0;
      found_q     <= 1'b0;
      status_q    <= mdfs_pkg::ST_OK;
      rx_q        <= '0;
      ry_q        <= '0;
      out_valid_q <= 1'b0;
      out_item_q  <= '0;
    end else begin
      if (cfg_we_i) begin
        case (cfg_idx_i)
          mdfs_pkg::CFG_WIDTH:  width_q   <= cfg_data_i;
          mdfs_pkg::CFG_HEIGHT: height_q  <= cfg_data_i;
          mdfs_pkg::CFG_STARTX: start_x_q <= cfg_data_i;
          mdfs_pkg::CFG_STARTY: start_y_q <= cfg_data_i;
          mdfs_pkg::CFG_GOALX:  goal_x_q  <= cfg_data_i;
          mdfs_pkg::CFG_GOALY:  goal_y_q  <= cfg_data_i;
          default: ;
        endcase
      end
      // output leaves; a finishing item reloads it in the same cycle instead
      if (out_valid_q && !out_stall_i && (state_q != S_DONE)) begin
        out_valid_q <= 1'b0;
      end
      case (state_q)
        S_IDLE: begin
          if (accept) begin
            rx_q <= '0;
            ry_q <= '0;
            case (in_item_i.operation)
              mdfs_pkg::OP_CLEAR: begin
                status_q <= mdfs_pkg::ST_OK;
                state_q  <= S_DONE;
              end
              mdfs_pkg::OP_BLOCK: begin
                status_q <= blk_in ? mdfs_pkg::ST_OK : mdfs_pkg::ST_RANGE;
                state_q  <= S_DONE;
              end
              mdfs_pkg::OP_SOLVE: begin
                status_q <= mdfs_pkg::ST_OK;
                state_q  <= S_START;
              end
              default: begin
                if ({1'b0, in_item_i.path_index} < plen) begin
                  status_q <= mdfs_pkg::ST_OK;
                  state_q  <= S_READ_WAIT;
                end else begin
                  status_q <= mdfs_pkg::ST_INDEX;
                  state_q  <= S_DONE;
                end
              end
            endcase
          end
        end
        // push the start once the visited sweep, if any, is over
        S_START: begin
          if (!map_busy) begin
            depth_q <= DW'(1);
            found_q <= 1'b0;
            top_x_q <= start_x_q;
            top_y_q <= start_y_q;
            state_q <= S_TOP;
          end
        end
        S_TOP: begin
          dir_q <= '0;
          if ((top_x_q == goal_x_q) && (top_y_q == goal_y_q)) begin
            found_q <= 1'b1;
            state_q <= S_DONE;
          end else begin
            state_q <= S_PROBE;
          end
        end
        S_PROBE: begin
          if (pop_now) begin
            depth_q <= depth_q - DW'(1);
            state_q <= (depth_q == DW'(1)) ? S_DONE : S_POP_WAIT;
          end else if (nb_in) begin
            state_q <= S_EVAL;
          end else begin
            dir_q <= dir_q + 2'd1;
          end
        end
        S_EVAL: begin
          if (enter) begin
            depth_q <= depth_q + DW'(1);
            top_x_q <= nb_x[CW-1:0];
            top_y_q <= nb_y[CW-1:0];
            state_q <= S_TOP;
          end else if (pop_now) begin
            depth_q <= depth_q - DW'(1);
            state_q <= (depth_q == DW'(1)) ? S_DONE : S_POP_WAIT;
          end else begin
            dir_q   <= dir_q + 2'd1;
            state_q <= S_PROBE;
          end
        end
        // new top of stack arrives from memory
        S_POP_WAIT: begin
          top_x_q <= stk_rd_q.x;
          top_y_q <= stk_rd_q.y;
          state_q <= S_TOP;
        end
        S_READ_WAIT: begin
          rx_q    <= stk_rd_q.x;
          ry_q    <= stk_rd_q.y;
          state_q <= S_DONE;
        end
        S_DONE: begin
          if (!out_valid_q || !out_stall_i) begin
            out_valid_q            <= 1'b1;
            out_item_q.status      <= status_q;
            out_item_q.found       <= found_q;
            out_item_q.path_length <= plen;
            out_item_q.out_x       <= rx_q;
            out_item_q.out_y       <= ry_q;
            state_q                <= S_IDLE;
          end
        end
        default: state_q <= S_IDLE;
      endcase
    end
  end

  // a found path always holds at least the start
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_item_o.found |-> out_item_o.path_length != '0)
    else $error("found result with empty path");

  // no item enters while the maps are being swept
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    map_busy |-> in_stall_o)
    else $error("item accepted during map sweep");

  // a probe answer is only evaluated right after its read
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == S_EVAL |-> $past(state_q) == S_PROBE)
    else $error("evaluate without probe read");

  // waiting on a popped top means the stack still holds entries
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == S_POP_WAIT |-> depth_q != '0)
    else $error("pop wait with empty stack");

endmodule
